[rtl/nv21rgb_pkg.sv]
// nv21rgb_pkg: shared types, constants and arithmetic helpers for the
// NV21 to RGB888 converter.
// No dependencies.
package nv21rgb_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // frame geometry
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 10;
  localparam int POS_W    = 20;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 9;
  localparam int RESET_WIDTH_I  = 640;
  localparam int RESET_HEIGHT_I = 480;
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(RESET_WIDTH_I);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(RESET_HEIGHT_I);
  localparam logic [POS_W-1:0] RESET_LUMA_LEN =
    POS_W'(RESET_WIDTH_I * RESET_HEIGHT_I);
  localparam logic [POS_W-1:0] RESET_TOTAL_M1 =
    POS_W'((RESET_WIDTH_I * RESET_HEIGHT_I * 3) / 2 - 1);
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 10'd512;

  // luma plane storage
  localparam int MAX_FRAME_PIXELS = 524288;
  localparam int LUMA_AW = $clog2(MAX_FRAME_PIXELS);

  // chroma index divider: quotient bits per resync
  localparam int DIV_W     = 17;
  localparam int DIV_CNT_W = 5;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [1:0] QUAD_LAST_K = 2'd3;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_SIZE,
    RS_TOTAL,
    RS_PLACE,
    RS_DIVIDE,
    RS_ADDRESS
  } resync_state_t;

  typedef struct packed {
    logic             frame_done;
    logic             quad_last;
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_column;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
  } pixel_t;

  // force even, then clamp to 2..max
  function automatic logic [WIDTH_W-1:0] clamp_width(logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] e;
    e = {v[WIDTH_W-1:1], 1'b0};
    priority if (e < 11'd2) return 11'd2;
    else if (e > MAX_WIDTH) return MAX_WIDTH;
    else return e;
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(logic [HEIGHT_W-1:0] v);
    logic [HEIGHT_W-1:0] e;
    e = {v[HEIGHT_W-1:1], 1'b0};
    priority if (e < 10'd2) return 10'd2;
    else if (e > MAX_HEIGHT) return MAX_HEIGHT;
    else return e;
  endfunction

  // floor(360*dv/256)
  function automatic logic signed [8:0] red_delta(logic signed [7:0] dv);
    logic signed [17:0] p;
    p = dv * 18'sd360;
    return 9'(p >>> 8);
  endfunction

  // -floor((88*du + 184*dv)/256), negated so every channel adds
  function automatic logic signed [8:0] green_delta(logic signed [7:0] du,
                                                    logic signed [7:0] dv);
    logic signed [17:0] p;
    logic signed [17:0] q;
    p = du * 18'sd88 + dv * 18'sd184;
    q = p >>> 8;
    return 9'(-q);
  endfunction

  // floor(455*du/256)
  function automatic logic signed [8:0] blue_delta(logic signed [7:0] du);
    logic signed [17:0] p;
    p = du * 18'sd455;
    return 9'(p >>> 8);
  endfunction

  // y + delta, saturated to 0..255
  function automatic logic [7:0] pixel_channel(logic [7:0] y,
                                               logic signed [8:0] delta);
    logic signed [10:0] s;
    s = $signed({3'b000, y}) + 11'(delta);
    priority if (s < 11'sd0) return 8'd0;
    else if (s > 11'sd255) return 8'hFF;
    else return s[7:0];
  endfunction

endpackage

[rtl/nv21_to_rgb_converter.sv]
// nv21_to_rgb_converter: NV21 byte stream in, RGB888 pixels out by 2x2 quad.
// Holds the luma plane, the chroma resync divider and the result queue.
// Depends on nv21rgb_pkg.
//
// Path: an accepted U byte loads the quad job; each of its four luma reads is
//   issued when the result queue has room, held in the read-data stage, then
//   pushed into the queue for output; the reads follow one per cycle while it has room.
// Throughput: luma and V bytes 1 per cycle while s_tready is high; a U byte
//   holds the luma read port for its four reads; luma bytes and the next U byte wait for them.
// Reset: sync, active high; size returns to 640x480, position and counters to
//   zero. The luma memory is not cleared. After a frame_width/frame_height
//   write, s_tready stays low while the quad position is recomputed: size,
//   total, place and, inside the chroma plane, the 17-step divider and address.
module nv21_to_rgb_converter (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [nv21rgb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nv21rgb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // byte requests in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // [7:0] frame_byte
  // pixel requests out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [33:24] pixel_column,
  // [42:34] pixel_row, [47:43] zero
  output logic [47:0]                        m_tdata,
  output logic                               m_tuser,  // [0] quad_last
  output logic                               m_tlast   // frame_done
);
  import nv21rgb_pkg::*;

  // ---------------- configuration and derived geometry ----------------
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [WIDTH_W-1:0]  w_eff;      // clamped width
  logic [POS_W-1:0]    luma_len;   // w*h
  logic [POS_W-1:0]    total_m1;   // 1.5*w*h - 1, offset of the last U byte

  // ---------------- stream position ----------------
  logic [POS_W-1:0]    byte_position;
  logic [7:0]          held_v;
  // top-left pixel of the next quad
  logic [COL_W-1:0]    quad_col;
  logic [ROW_W-1:0]    quad_row;
  logic [LUMA_AW-1:0]  quad_addr;

  // ---------------- resync sequencer ----------------
  resync_state_t       rs_state, rs_state_next;
  logic [DIV_W-1:0]    div_dvd;    // dividend in, quotient out
  logic [ROW_W-1:0]    div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [COL_W-1:0]    half_w;
  logic [COL_W-1:0]    div_trial;
  logic                div_ge;
  logic [POS_W-1:0]    pos_off;
  logic                cfg_hit;

  // ---------------- quad job (4 luma reads) ----------------
  logic                job_valid;
  logic [1:0]          job_k;
  logic [LUMA_AW-1:0]  job_addr;
  logic [COL_W-1:0]    job_col;
  logic [ROW_W-1:0]    job_row;
  logic                job_last;
  logic signed [8:0]   job_dr, job_dg, job_db;

  // ---------------- read-data stage ----------------
  logic                s2_valid;
  logic [COL_W-1:0]    s2_col;
  logic [ROW_W-1:0]    s2_row;
  logic                s2_quad_last;
  logic                s2_frame_done;
  logic signed [8:0]   s2_dr, s2_dg, s2_db;

  // ---------------- luma memory ----------------
  logic [7:0]          luma_mem [MAX_FRAME_PIXELS];
  logic [7:0]          luma_rdata;
  logic [LUMA_AW-1:0]  luma_raddr;

  // ---------------- result queue ----------------
  pixel_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  fifo_wr, fifo_rd;
  logic [FIFO_AW:0]    fifo_count;
  logic [FIFO_AW:0]    fifo_load;
  pixel_t              pix;
  pixel_t              head;
  logic                push, pop;

  // ---------------- request decode ----------------
  logic                in_luma, is_v, frame_end, row_wrap;
  logic                issue, job_free;
  logic                acc, acc_luma, acc_v, acc_u;
  logic signed [7:0]   du, dv;

  assign cfg_hit = cfg_wr_en &&
                   (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  // luma_len is a multiple of 4, so V/U parity is bit 0 of the position
  assign in_luma   = byte_position < luma_len;
  assign is_v      = !byte_position[0];
  assign frame_end = byte_position == total_m1;
  assign row_wrap  = ({1'b0, quad_col} + 11'd2) == w_eff;

  // A read is issued only when the queue is sure to have room when its data
  // is pushed from the read-data stage.
  assign fifo_load = fifo_count + {{FIFO_AW{1'b0}}, s2_valid};
  assign issue     = job_valid && (fifo_load < (FIFO_AW+1)'(FIFO_DEPTH - 1));
  assign job_free  = !job_valid || (issue && job_k == QUAD_LAST_K);

  // V bytes go through while a quad drains; luma writes wait for the quad's
  // reads to be issued so a short frame cannot overwrite entries still needed.
  assign s_tready = (rs_state == RS_IDLE) &&
                    (in_luma ? !job_valid : (is_v || job_free));
  assign acc      = s_tvalid && s_tready;
  assign acc_luma = acc && in_luma;
  assign acc_v    = acc && !in_luma && is_v;
  assign acc_u    = acc && !in_luma && !is_v;

  // x - 128 as two's complement is x with the top bit flipped
  assign du = $signed(s_tdata ^ 8'h80);
  assign dv = $signed(held_v ^ 8'h80);

  assign luma_raddr = job_addr + (job_k[1] ? LUMA_AW'(w_eff) : '0) +
                      LUMA_AW'(job_k[0]);

  // divider step: restoring, one quotient bit per cycle
  assign half_w    = w_eff[WIDTH_W-1:1];
  assign div_trial = {div_rem, div_dvd[DIV_W-1]};
  assign div_ge    = div_trial >= half_w;
  assign pos_off   = byte_position - luma_len;

  // ---------------- resync state machine ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rs_state <= RS_IDLE;
    end else begin
      rs_state <= rs_state_next;
    end
  end

  always_comb begin
    rs_state_next = rs_state;
    if (cfg_hit) begin
      rs_state_next = RS_SIZE;
    end else begin
      unique case (rs_state)
        RS_IDLE:    rs_state_next = RS_IDLE;
        RS_SIZE:    rs_state_next = RS_TOTAL;
        RS_TOTAL:   rs_state_next = RS_PLACE;
        RS_PLACE: begin
          // outside the chroma plane the counters simply restart at zero
          if (byte_position > total_m1 || byte_position < luma_len) begin
            rs_state_next = RS_IDLE;
          end else begin
            rs_state_next = RS_DIVIDE;
          end
        end
        RS_DIVIDE: begin
          if (div_cnt == DIV_CNT_W'(DIV_W - 1)) begin
            rs_state_next = RS_ADDRESS;
          end
        end
        RS_ADDRESS: rs_state_next = RS_IDLE;
        default:    rs_state_next = RS_IDLE;
      endcase
    end
  end

  // ---------------- geometry, position and quad counters ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RESET_WIDTH;
      frame_height  <= RESET_HEIGHT;
      w_eff         <= RESET_WIDTH;
      luma_len      <= RESET_LUMA_LEN;
      total_m1      <= RESET_TOTAL_M1;
      byte_position <= '0;
      held_v        <= '0;
      quad_col      <= '0;
      quad_row      <= '0;
      quad_addr     <= '0;
      div_cnt       <= '0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_FRAME_WIDTH) begin
          frame_width <= cfg_data[WIDTH_W-1:0];
        end else if (cfg_index == CFG_FRAME_HEIGHT) begin
          frame_height <= cfg_data[HEIGHT_W-1:0];
        end
      end

      unique case (rs_state)
        RS_IDLE: begin
          if (acc) begin
            byte_position <= frame_end ? '0 : byte_position + 20'd1;
          end
          if (acc_v) begin
            held_v <= s_tdata;
          end
          if (acc_u) begin
            priority if (frame_end) begin
              quad_col  <= '0;
              quad_row  <= '0;
              quad_addr <= '0;
            end else if (row_wrap) begin
              // next chroma row: skip the bottom luma row of this quad row
              quad_col  <= '0;
              quad_row  <= quad_row + 9'd2;
              quad_addr <= quad_addr + LUMA_AW'(w_eff) + 19'd2;
            end else begin
              quad_col  <= quad_col + 10'd2;
              quad_addr <= quad_addr + 19'd2;
            end
          end
        end
        RS_SIZE: begin
          w_eff    <= clamp_width(frame_width);
          luma_len <= POS_W'(clamp_width(frame_width)) *
                      POS_W'(clamp_height(frame_height));
        end
        RS_TOTAL: begin
          total_m1 <= luma_len + {1'b0, luma_len[POS_W-1:1]} - 20'd1;
        end
        RS_PLACE: begin
          quad_col  <= '0;
          quad_row  <= '0;
          quad_addr <= '0;
          if (byte_position > total_m1) begin
            byte_position <= '0;
          end
          div_dvd <= pos_off[DIV_W:1];  // chroma pair index
          div_rem <= '0;
          div_cnt <= '0;
        end
        RS_DIVIDE: begin
          div_rem <= div_ge ? ROW_W'(div_trial - half_w) : div_trial[ROW_W-1:0];
          div_dvd <= {div_dvd[DIV_W-2:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
        end
        RS_ADDRESS: begin
          // quotient is the chroma row (< 256), remainder the chroma column
          quad_row  <= {div_dvd[7:0], 1'b0};
          quad_col  <= {div_rem, 1'b0};
          quad_addr <= LUMA_AW'(POS_W'({div_dvd[7:0], 1'b0}) * POS_W'(w_eff) +
                                POS_W'({div_rem, 1'b0}));
        end
        default: ;
      endcase
    end
  end

  // ---------------- quad job ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_k     <= '0;
    end else begin
      if (issue) begin
        job_k <= job_k + 2'd1;
        if (job_k == QUAD_LAST_K) begin
          job_valid <= 1'b0;
        end
      end
      if (acc_u) begin
        job_valid <= 1'b1;
        job_k     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_u) begin
      job_addr <= quad_addr;
      job_col  <= quad_col;
      job_row  <= quad_row;
      job_last <= frame_end;
      job_dr   <= red_delta(dv);
      job_dg   <= green_delta(du, dv);
      job_db   <= blue_delta(du);
    end
  end

  // ---------------- luma memory ----------------
  always_ff @(posedge clk) begin
    if (acc_luma) begin
      luma_mem[byte_position[LUMA_AW-1:0]] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      luma_rdata <= luma_mem[luma_raddr];
    end
  end

  // ---------------- read-data stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_col        <= job_col + COL_W'(job_k[0]);
      s2_row        <= job_row + ROW_W'(job_k[1]);
      s2_quad_last  <= job_k == QUAD_LAST_K;
      s2_frame_done <= (job_k == QUAD_LAST_K) && job_last;
      s2_dr         <= job_dr;
      s2_dg         <= job_dg;
      s2_db         <= job_db;
    end
  end

  always_comb begin
    pix.red          = pixel_channel(luma_rdata, s2_dr);
    pix.green        = pixel_channel(luma_rdata, s2_dg);
    pix.blue         = pixel_channel(luma_rdata, s2_db);
    pix.pixel_column = s2_col;
    pix.pixel_row    = s2_row;
    pix.quad_last    = s2_quad_last;
    pix.frame_done   = s2_frame_done;
  end

  // ---------------- result queue ----------------
  assign push = s2_valid;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr    <= '0;
      fifo_rd    <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        fifo_wr <= fifo_wr + 2'd1;
      end
      if (pop) begin
        fifo_rd <= fifo_rd + 2'd1;
      end
      fifo_count <= fifo_count + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[fifo_wr] <= pix;
    end
  end

  assign head     = fifo_mem[fifo_rd];
  assign m_tvalid = fifo_count != '0;
  assign m_tdata  = {5'b00000, head.pixel_row, head.pixel_column,
                     head.blue, head.green, head.red};
  assign m_tuser  = head.quad_last;
  assign m_tlast  = head.frame_done;

  // ---------------- assertions ----------------
  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (fifo_count < (FIFO_AW+1)'(FIFO_DEPTH) || pop))
    else $error("result queue overflow");

  a_quad_tail: assert property (@(posedge clk) disable iff (rst)
    (issue && job_k == QUAD_LAST_K) |=> (s2_valid && s2_quad_last))
    else $error("fourth read of a quad not tagged as quad end");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (rs_state == RS_IDLE) |-> (byte_position <= total_m1))
    else $error("byte position beyond frame while accepting");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    issue |-> (POS_W'(luma_raddr) < luma_len))
    else $error("luma read outside current plane");

  a_done_on_tail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("frame end on a pixel that does not close a quad");

endmodule

[tb/tb.sv]
// tb: self-checking bench for nv21_to_rgb_converter; streams NV21 frames of many
// sizes and checks every RGB pixel against a behavioral prediction.
// Depends on nv21rgb_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb;
  import nv21rgb_pkg::*;

  localparam int SMALL_BYTES = 420;      // random bytes sent at small sizes
  localparam int CYCLE_LIMIT = 100_000;
  localparam int HOLD_CYCLES = 300;      // long output hold-off
  localparam int SETTLE      = 8;        // pipeline is 3 deep; margin on top
  localparam int DRAIN       = 32;

  // first eight bytes walk a one through every bit; the rest are three
  // 2x2 frames: luma x4, V, U
  localparam logic [7:0] DIRECTED_BYTES [26] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00,   // both clamps, V=U=0
    8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'hFF,   // V=U=255
    8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h80, 8'h80    // neutral chroma
  };

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  // Expected-pixel store plus a behavioral copy of the converter state.
  class pixel_scoreboard;
    logic [7:0]          luma_mem [MAX_FRAME_PIXELS];
    int unsigned         luma_prefix;   // entries [0, luma_prefix) hold data
    logic [POS_W-1:0]    byte_pos;
    logic [7:0]          held_v;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    pixel_t              pixels_due [$];
    int                  errors;

    function new();
      luma_prefix = 0;
      byte_pos    = '0;
      held_v      = '0;
      width_reg   = RESET_WIDTH;
      height_reg  = RESET_HEIGHT;
      errors      = 0;
    endfunction

    static function int unsigned even_clamp(int unsigned raw, int unsigned hi);
      int unsigned e;
      e = raw & 32'hFFFF_FFFE;
      if (e < 2) e = 2;
      if (e > hi) e = hi;
      return e;
    endfunction

    static function logic [7:0] saturate(int x);
      if (x < 0) return 8'd0;
      if (x > 255) return 8'd255;
      return 8'(x);
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH) width_reg = data[WIDTH_W-1:0];
      else height_reg = data[HEIGHT_W-1:0];
    endfunction

    function int unsigned cols();
      return even_clamp(width_reg, 1024);
    endfunction

    function int unsigned luma_bytes();
      return cols() * even_clamp(height_reg, 512);
    endfunction

    function int unsigned frame_bytes();
      return luma_bytes() * 3 / 2;
    endfunction

    // where the next byte lands; a size change can push it past the frame
    function int unsigned frame_offset();
      return (byte_pos >= frame_bytes()) ? 0 : int'(byte_pos);
    endfunction

    // called for every accepted byte request
    function void note_byte(logic [7:0] b);
      int unsigned w, luma, total, pos, off, c, crow, ccol, row, col;
      int dv, du, dr, dg, db, y;
      pixel_t px;
      w     = cols();
      luma  = luma_bytes();
      total = luma * 3 / 2;
      pos   = frame_offset();
      byte_pos = POS_W'(pos + 1);
      if (pos < luma) begin
        luma_mem[pos] = b;
        if (pos == luma_prefix) luma_prefix++;
        return;
      end
      off = pos - luma;
      if (off % 2 == 0) begin
        held_v = b;
        return;
      end
      // U byte: four pixels of the quad, raster order inside the quad
      c    = off / 2;
      crow = c / (w / 2);
      ccol = c % (w / 2);
      dv = int'(held_v) - 128;
      du = int'(b) - 128;
      dr = (360 * dv) >>> 8;
      dg = (88 * du + 184 * dv) >>> 8;
      db = (455 * du) >>> 8;
      for (int k = 0; k < 4; k++) begin
        row = 2 * crow + k / 2;
        col = 2 * ccol + k % 2;
        y   = int'(luma_mem[row * w + col]);
        px.red          = saturate(y + dr);
        px.green        = saturate(y - dg);
        px.blue         = saturate(y + db);
        px.pixel_column = COL_W'(col);
        px.pixel_row    = ROW_W'(row);
        px.quad_last    = (k == 3);
        px.frame_done   = (k == 3) && (pos + 1 >= total);
        pixels_due.push_back(px);
      end
      if (pos + 1 >= total) byte_pos = '0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_field(string name, int got, int want, pixel_t at);
      if (got != want)
        report_mismatch($sformatf("%s at col %0d row %0d: got %0d, expected %0d",
                                  name, at.pixel_column, at.pixel_row, got, want));
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel col %0d row %0d",
                                  got.pixel_column, got.pixel_row));
        return;
      end
      want = pixels_due.pop_front();
      check_field("red", got.red, want.red, want);
      check_field("green", got.green, want.green, want);
      check_field("blue", got.blue, want.blue, want);
      check_field("pixel_column", got.pixel_column, want.pixel_column, want);
      check_field("pixel_row", got.pixel_row, want.pixel_row, want);
      check_field("quad_last", got.quad_last, want.quad_last, want);
      check_field("frame_done", got.frame_done, want.frame_done, want);
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [47:0]            m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  pixel_scoreboard sb = new();
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  hold_req = 1'b0;       // asks the receiver for one long hold-off
  bit  pressure_armed = 1'b0; // fire hold_req at the next chroma byte

  nv21_to_rgb_converter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // pixel monitor: tlast, tuser and tdata[42:0] line up with pixel_t, MSB first
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_pixel(pixel_t'({m_tlast, m_tuser, m_tdata[42:0]}));
  end

  // receiver: random-duty stretches, plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       stretch;
    mode    = RX_ALWAYS;
    stretch = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stretch == 0) begin
        mode    = rx_mode_t'($urandom_range(0, 3));
        stretch = $urandom_range(1, 64);
      end
      stretch--;
      case (mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Offer one byte; bursts of random length with random gaps in between.
  // Returns in the step of the accepting edge with tvalid still high.
  task automatic offer_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    burst_left--;
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      // long hold-off starts with the chroma plane so the output queue backs up
      if (pressure_armed && sb.frame_offset() >= sb.luma_bytes()) begin
        hold_req       = 1'b1;
        pressure_armed = 1'b0;
      end
      offer_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // drop tvalid, let every pixel out, then allow the pipeline to empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // width then height on consecutive edges; the block must be idle
  task automatic write_size(logic [CFG_DATA_W-1:0] w_raw, logic [CFG_DATA_W-1:0] h_raw);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    sb.set_reg(CFG_FRAME_WIDTH, w_raw);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    sb.set_reg(CFG_FRAME_HEIGHT, h_raw);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int          phase, small_bytes, frames, remaining;
    int unsigned w_raw, h_raw, cur_w, cur_h, luma;
    bit          found;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // a few luma bytes at the reset size, then shrink the frame under them:
    // odd width and a height with only the unused bit set both clamp to 2,
    // and the position restarts since it is past the new 2x2 frame
    for (int i = 0; i < 8; i++) offer_byte(DIRECTED_BYTES[i]);
    wait_idle();
    write_size(11'd1, 11'h400);
    for (int i = 8; i < 26; i++) offer_byte(DIRECTED_BYTES[i]);

    // Random phases: new size, then finish the current frame (restarted or
    // continued under the new size) and send a few more. Phase 0 runs two
    // whole frames with the long output hold-off from its first chroma byte,
    // so the next frame's luma backs up behind it. Size changes mid-frame
    // only keep going where every luma entry the new size reads has already
    // been written.
    cur_w = 1;
    cur_h = 11'h400;
    phase = 0;
    small_bytes = 0;
    while (small_bytes < SMALL_BYTES) begin
      wait_idle();
      found = 1'b0;
      for (int t = 0; t < 20 && !found; t++) begin
        if ($urandom_range(0, 7) == 0) begin
          // wide and flat
          w_raw = $urandom_range(14, 63);
          h_raw = $urandom_range(0, 3);
        end else begin
          w_raw = $urandom_range(0, 13);
          h_raw = $urandom_range(0, 9);
        end
        if ($urandom_range(0, 1)) h_raw = h_raw | 32'h400;
        luma = pixel_scoreboard::even_clamp(w_raw, 1024) *
               pixel_scoreboard::even_clamp(h_raw & 32'h3FF, 512);
        found = (sb.byte_pos == 0) || (sb.byte_pos >= luma * 3 / 2) ||
                (luma <= sb.luma_prefix);
      end
      if (!found) begin
        w_raw = cur_w;
        h_raw = cur_h;
      end
      write_size(CFG_DATA_W'(w_raw), CFG_DATA_W'(h_raw));
      cur_w = w_raw;
      cur_h = h_raw;
      if (phase == 0) pressure_armed = 1'b1;
      frames = (phase == 0) ? 2 : $urandom_range(1, 2);
      for (int f = 0; f < frames; f++) begin
        remaining = sb.frame_bytes() - sb.frame_offset();
        // sometimes abandon the last frame part way through
        if (f == frames - 1 && phase != 0 && $urandom_range(0, 2) == 0)
          remaining = $urandom_range(1, remaining);
        send_random(remaining);
        small_bytes += remaining;
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
